>>> design/nrvs_pkg.sv
// Shared types and constants for the note retrigger volume stepper.
`default_nettype none
package nrvs_pkg;

   // Volume modes selected by the high nibble of the effect parameter
   localparam logic [3:0] MODE_SUB1   = 4'h1;
   localparam logic [3:0] MODE_SUB2   = 4'h2;
   localparam logic [3:0] MODE_SUB4   = 4'h3;
   localparam logic [3:0] MODE_SUB8   = 4'h4;
   localparam logic [3:0] MODE_SUB16  = 4'h5;
   localparam logic [3:0] MODE_TWO3RD = 4'h6;
   localparam logic [3:0] MODE_HALF   = 4'h7;
   localparam logic [3:0] MODE_ADD1   = 4'h9;
   localparam logic [3:0] MODE_ADD2   = 4'hA;
   localparam logic [3:0] MODE_ADD4   = 4'hB;
   localparam logic [3:0] MODE_ADD8   = 4'hC;
   localparam logic [3:0] MODE_ADD16  = 4'hD;
   localparam logic [3:0] MODE_THREE2 = 4'hE;
   localparam logic [3:0] MODE_DOUBLE = 4'hF;

   localparam logic [6:0] VOL_MAX    = 7'd64;
   // floor(x / 3) == (x * 171) >> 9 for any 8-bit x
   localparam logic [7:0] DIV3_RECIP = 8'd171;
   localparam int         DIV3_SHIFT = 9;

   typedef struct packed {
      logic       enable;
      logic [7:0] effect_param;
      logic       note_start;
      logic [6:0] volume_in;
   } nrvs_item_type;

   typedef struct packed {
      logic [6:0] volume_out;
      logic       retrigger;
   } nrvs_result_type;

endpackage
`default_nettype wire

>>> design/nrvs_core.sv
// Tick countdown register and the volume step logic for one tick.
`default_nettype none
module nrvs_core (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    step,
   input  wire nrvs_pkg::nrvs_item_type item,
   output nrvs_pkg::nrvs_result_type    result
);
   import nrvs_pkg::*;

   logic [3:0]  countdown_ff;
   logic [3:0]  countdown_in;
   logic [3:0]  reload_val;
   logic [3:0]  cnt_eff;
   logic        reload;
   logic        retrig;
   logic [3:0]  mode;
   logic [9:0]  vol_ext;
   logic [9:0]  vol_mod;
   logic [7:0]  two_v1;
   logic [15:0] div3_prod;
   logic [8:0]  three_v1;
   logic [6:0]  vol_clamped;

   always_comb begin
      reload     = item.enable && (countdown_ff == 4'd0);
      reload_val = (item.effect_param[3:0] == 4'd0) ? 4'd1 : item.effect_param[3:0];
      cnt_eff    = reload ? reload_val : countdown_ff;
      // hold the counter on disabled ticks
      countdown_in = (step && item.enable) ? (cnt_eff - 4'd1) : countdown_ff;
      retrig       = reload && !item.note_start;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= 4'd0;
      end else begin
         countdown_ff <= countdown_in;
      end
   end

   always_comb begin
      mode      = item.effect_param[7:4];
      vol_ext   = {3'b000, item.volume_in};
      two_v1    = {item.volume_in, 1'b1};
      div3_prod = 16'(two_v1 * DIV3_RECIP);
      three_v1  = 9'({item.volume_in, 1'b0}) + 9'(item.volume_in) + 9'd1;
      case (mode)
         MODE_SUB1:   vol_mod = vol_ext - 10'd1;
         MODE_SUB2:   vol_mod = vol_ext - 10'd2;
         MODE_SUB4:   vol_mod = vol_ext - 10'd4;
         MODE_SUB8:   vol_mod = vol_ext - 10'd8;
         MODE_SUB16:  vol_mod = vol_ext - 10'd16;
         MODE_TWO3RD: vol_mod = 10'(div3_prod[15:DIV3_SHIFT]);
         MODE_HALF:   vol_mod = (vol_ext + 10'd1) >> 1;
         MODE_ADD1:   vol_mod = vol_ext + 10'd1;
         MODE_ADD2:   vol_mod = vol_ext + 10'd2;
         MODE_ADD4:   vol_mod = vol_ext + 10'd4;
         MODE_ADD8:   vol_mod = vol_ext + 10'd8;
         MODE_ADD16:  vol_mod = vol_ext + 10'd16;
         MODE_THREE2: vol_mod = 10'(three_v1[8:1]);
         MODE_DOUBLE: vol_mod = {vol_ext[8:0], 1'b0};
         default:     vol_mod = vol_ext;
      endcase
      // the sign bit marks an underflow
      if (vol_mod[9]) begin
         vol_clamped = 7'd0;
      end else if (vol_mod > 10'(VOL_MAX)) begin
         vol_clamped = VOL_MAX;
      end else begin
         vol_clamped = vol_mod[6:0];
      end
      result.retrigger  = retrig;
      result.volume_out = retrig ? vol_clamped : item.volume_in;
   end

endmodule
`default_nettype wire

>>> design/note_retrigger_volume_stepper.sv
// Top level of the note retrigger volume stepper: input and result registers.
//
//   channel  direction  tdata                           tuser
//   req      in         effect_param, volume_in         enable, note_start
//   rsp      out        volume_out                      retrigger
//
// One tick per cycle while the result channel is not stalled; each tick is held
// in the input register and then moves on to the result register.
// The countdown advances as a tick moves from the input to the result register.
// Reset clears both valid flags and the countdown.
// A stalled result holds; the input register still takes a beat while empty.
`default_nettype none
module note_retrigger_volume_stepper (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [7:0] effect_param, [14:8] volume_in, [15] zero
   input  wire logic [1:0]  req_tuser,   // [0] enable, [1] note_start
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata,   // [6:0] volume_out, [7] zero
   output logic             rsp_tuser    // [0] retrigger
);
   import nrvs_pkg::*;

   logic            in_valid_ff;
   logic            in_valid_in;
   nrvs_item_type   item_ff;
   logic            out_valid_ff;
   logic            out_valid_in;
   nrvs_result_type result_ff;
   nrvs_result_type result_calc;
   logic            advance;
   logic            req_beat;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_beat   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in  = req_beat ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : ((rsp_tready) ? 1'b0 : out_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         item_ff.enable       <= req_tuser[0];
         item_ff.note_start   <= req_tuser[1];
         item_ff.effect_param <= req_tdata[7:0];
         item_ff.volume_in    <= req_tdata[14:8];
      end
      if (advance) begin
         result_ff <= result_calc;
      end
   end

   nrvs_core u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (item_ff),
      .result (result_calc)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, result_ff.volume_out};
   assign rsp_tuser  = result_ff.retrigger;

endmodule
`default_nettype wire
